### rtl/gbbs_pkg.sv
`default_nettype none

package gbbs_pkg;

    localparam int GRID_CELLS = 16;
    localparam int CELL_IDX_W = 4;

    localparam int CFG_W      = 7;
    localparam int PIXEL_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int LEFT_X_W   = 10;
    localparam int GWIDTH_W   = 7;
    localparam int TRIM_W     = 7;
    localparam int OUT_DATA_W = INDEX_W + LEFT_X_W + GWIDTH_W + TRIM_W;

    localparam logic CFG_CELL_WIDTH  = 1'b0;
    localparam logic CFG_CELL_HEIGHT = 1'b1;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_TRIM  = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_EMIT,
        ST_TRIM
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit_step;
        logic emit_trim;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic trig;
        logic last_cell;
        logic frame_flag;
    } sts_t;

endpackage

`default_nettype wire

### rtl/gbbs_ctrl.sv
`default_nettype none

module gbbs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  gbbs_pkg::sts_t sts,
    output gbbs_pkg::cmd_t cmd
);
    import gbbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.trig) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (sts.last_cell) begin
                        state_next = sts.frame_flag ? ST_TRIM : ST_RUN;
                    end
                end
            end
            ST_TRIM: begin
                if (sts.out_free) begin
                    cmd.emit_trim = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    a_no_load_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_step || cmd.emit_trim) |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_trim_only_at_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRIM) |-> sts.frame_flag)
        else $error("top trim result outside frame end");

    a_no_accept_during_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && (cmd.emit_step || cmd.emit_trim)))
        else $error("pixel accepted during result burst");

endmodule

`default_nettype wire

### rtl/gbbs_datapath.sv
`default_nettype none

module gbbs_datapath #(
    parameter int MAX_CELL_SIZE = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic                               cfg_index,
    input  logic [gbbs_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [gbbs_pkg::PIXEL_W-1:0]       pixel,
    input  gbbs_pkg::cmd_t                     cmd,
    output gbbs_pkg::sts_t                     sts,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [gbbs_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                               out_kind,
    output logic                               out_last
);
    import gbbs_pkg::*;

    localparam int SZ_W  = $clog2(MAX_CELL_SIZE + 1);
    localparam int XIN_W = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
    localparam int ORG_W = $clog2(GRID_CELLS * MAX_CELL_SIZE);

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [SZ_W-1:0] r;
        if (v == '0) begin
            r = SZ_W'(1);
        end else if (32'(v) > 32'(MAX_CELL_SIZE)) begin
            r = SZ_W'(MAX_CELL_SIZE);
        end else begin
            r = SZ_W'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]      cw_cfg_reg, cw_cfg_next;
    logic [CFG_W-1:0]      ch_cfg_reg, ch_cfg_next;
    logic [XIN_W-1:0]      xin_reg, xin_next;
    logic [CELL_IDX_W-1:0] col_reg, col_next;
    logic [XIN_W-1:0]      yin_reg, yin_next;
    logic [CELL_IDX_W-1:0] row_reg, row_next;
    logic [GRID_CELLS-1:0] inked_reg, inked_next;
    logic [CELL_IDX_W-1:0] cnt_reg, cnt_next;
    logic                  frame_reg, frame_next;
    logic                  ovalid_reg, ovalid_next;

    logic [PIXEL_W-1:0]    background_reg, background_next;
    logic [XIN_W-1:0]      left_reg  [GRID_CELLS];
    logic [XIN_W-1:0]      left_next [GRID_CELLS];
    logic [XIN_W-1:0]      right_reg [GRID_CELLS];
    logic [XIN_W-1:0]      right_next[GRID_CELLS];
    logic [SZ_W-1:0]       top_reg, top_next;
    logic [ORG_W-1:0]      origin_reg, origin_next;
    logic [CELL_IDX_W-1:0] crow_reg, crow_next;
    logic [OUT_DATA_W-1:0] odata_reg, odata_next;
    logic                  okind_reg, okind_next;
    logic                  olast_reg, olast_next;

    logic [SZ_W-1:0]       cw, ch;
    logic                  xin_last, yin_last, line_end, trig, frame_end, frame_start;
    logic                  out_free;
    logic [ORG_W-1:0]      glyph_lx;
    logic [XIN_W:0]        glyph_span;
    logic [GWIDTH_W-1:0]   glyph_w;

    assign cw          = eff_size(cw_cfg_reg);
    assign ch          = eff_size(ch_cfg_reg);
    assign xin_last    = (SZ_W'(xin_reg) + SZ_W'(1)) == cw;
    assign yin_last    = (SZ_W'(yin_reg) + SZ_W'(1)) == ch;
    assign line_end    = (col_reg == CELL_IDX_W'(GRID_CELLS - 1)) && xin_last;
    assign trig        = line_end && yin_last;
    assign frame_end   = trig && (row_reg == CELL_IDX_W'(GRID_CELLS - 1));
    assign frame_start = (xin_reg == '0) && (col_reg == '0) && (yin_reg == '0)
                         && (row_reg == '0);
    assign out_free    = !ovalid_reg || out_ready;

    // box of the cell at the head of the record line
    assign glyph_span = {1'b0, right_reg[0]} - {1'b0, left_reg[0]} + (XIN_W + 1)'(1);
    assign glyph_lx   = origin_reg + (inked_reg[0] ? ORG_W'(left_reg[0]) : ORG_W'(0));
    assign glyph_w    = inked_reg[0] ? GWIDTH_W'(glyph_span) : GWIDTH_W'(cw);

    always_comb begin
        cw_cfg_next     = cw_cfg_reg;
        ch_cfg_next     = ch_cfg_reg;
        xin_next        = xin_reg;
        col_next        = col_reg;
        yin_next        = yin_reg;
        row_next        = row_reg;
        inked_next      = inked_reg;
        cnt_next        = cnt_reg;
        frame_next      = frame_reg;
        background_next = background_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        top_next        = top_reg;
        origin_next     = origin_reg;
        crow_next       = crow_reg;
        odata_next      = odata_reg;
        okind_next      = okind_reg;
        olast_next      = olast_reg;
        ovalid_next     = ovalid_reg;

        if (cmd.accept) begin
            if (xin_last) begin
                xin_next = '0;
                col_next = col_reg + CELL_IDX_W'(1);
                if (line_end) begin
                    if (yin_last) begin
                        yin_next = '0;
                        row_next = row_reg + CELL_IDX_W'(1);
                    end else begin
                        yin_next = yin_reg + XIN_W'(1);
                    end
                end
            end else begin
                xin_next = xin_reg + XIN_W'(1);
            end

            if (frame_start) begin
                background_next = pixel;
                top_next        = ch;
            end else if (pixel != background_reg) begin
                if (!inked_reg[col_reg]) begin
                    inked_next[col_reg] = 1'b1;
                    left_next[col_reg]  = xin_reg;
                    right_next[col_reg] = xin_reg;
                end else begin
                    if (xin_reg < left_reg[col_reg]) begin
                        left_next[col_reg] = xin_reg;
                    end
                    if (xin_reg > right_reg[col_reg]) begin
                        right_next[col_reg] = xin_reg;
                    end
                end
                if (SZ_W'(yin_reg) < top_reg) begin
                    top_next = SZ_W'(yin_reg);
                end
            end

            if (trig) begin
                cnt_next    = '0;
                origin_next = '0;
                crow_next   = row_reg;
                frame_next  = frame_end;
            end
        end

        if (out_ready) begin
            ovalid_next = 1'b0;
        end

        if (cmd.emit_step) begin
            odata_next  = {TRIM_W'(0), glyph_w, LEFT_X_W'(glyph_lx), crow_reg, cnt_reg};
            okind_next  = KIND_GLYPH;
            olast_next  = (cnt_reg == CELL_IDX_W'(GRID_CELLS - 1)) && !frame_reg;
            ovalid_next = 1'b1;
            // shift records toward the head, clearing from the tail
            for (int i = 0; i < GRID_CELLS - 1; i++) begin
                inked_next[i] = inked_reg[i + 1];
                left_next[i]  = left_reg[i + 1];
                right_next[i] = right_reg[i + 1];
            end
            inked_next[GRID_CELLS - 1] = 1'b0;
            left_next[GRID_CELLS - 1]  = '0;
            right_next[GRID_CELLS - 1] = '0;
            cnt_next    = cnt_reg + CELL_IDX_W'(1);
            origin_next = origin_reg + ORG_W'(cw);
        end

        if (cmd.emit_trim) begin
            odata_next  = {TRIM_W'(top_reg), GWIDTH_W'(0), LEFT_X_W'(0), INDEX_W'(0)};
            okind_next  = KIND_TRIM;
            olast_next  = 1'b1;
            ovalid_next = 1'b1;
        end

        // any valid register write restarts the frame
        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_CELL_WIDTH:  cw_cfg_next = cfg_wdata;
                CFG_CELL_HEIGHT: ch_cfg_next = cfg_wdata;
                default:         cw_cfg_next = cw_cfg_reg;
            endcase
            xin_next   = '0;
            col_next   = '0;
            yin_next   = '0;
            row_next   = '0;
            inked_next = '0;
            for (int i = 0; i < GRID_CELLS; i++) begin
                left_next[i]  = '0;
                right_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_cfg_reg <= CFG_W'(8);
            ch_cfg_reg <= CFG_W'(8);
            xin_reg    <= '0;
            col_reg    <= '0;
            yin_reg    <= '0;
            row_reg    <= '0;
            inked_reg  <= '0;
            cnt_reg    <= '0;
            frame_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            cw_cfg_reg <= cw_cfg_next;
            ch_cfg_reg <= ch_cfg_next;
            xin_reg    <= xin_next;
            col_reg    <= col_next;
            yin_reg    <= yin_next;
            row_reg    <= row_next;
            inked_reg  <= inked_next;
            cnt_reg    <= cnt_next;
            frame_reg  <= frame_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            background_reg <= '0;
        end else begin
            background_reg <= background_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        top_reg    <= top_next;
        origin_reg <= origin_next;
        crow_reg   <= crow_next;
        odata_reg  <= odata_next;
        okind_reg  <= okind_next;
        olast_reg  <= olast_next;
    end

    assign sts.out_free   = out_free;
    assign sts.trig       = trig;
    assign sts.last_cell  = cnt_reg == CELL_IDX_W'(GRID_CELLS - 1);
    assign sts.frame_flag = frame_reg;

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;

    a_records_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_step && (cnt_reg == CELL_IDX_W'(GRID_CELLS - 1))) |=> (inked_reg == '0))
        else $error("cell records not cleared after a row burst");

    a_trim_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && (okind_reg == KIND_TRIM)) |-> olast_reg)
        else $error("top trim result without last");

    a_trig_in_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && trig) |-> (col_reg == CELL_IDX_W'(GRID_CELLS - 1)))
        else $error("row burst started outside the last cell");

endmodule

`default_nettype wire

### rtl/glyph_cell_bounding_box_scanner_core.sv
// Pixels are taken one per cycle while scanning a cell row.
// The last pixel of a cell row's last line starts a burst: the state register enters the
// emit state, then 16 glyph boxes (17 results at frame end) enter the output register one
// per cycle while it is free, set by the single record line that shifts one cell to it per
// cycle; input stalls for the burst. Synchronous active-low reset sets both cell sizes to 8,
// clears the counters and the cell ink flags and empties the output register.
`default_nettype none

module glyph_cell_bounding_box_scanner_core #(
    parameter int MAX_CELL_SIZE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic                              cfg_index,
    input  logic [gbbs_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gbbs_pkg::PIXEL_W-1:0]      s_tdata,   // [31:0] pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] glyph_index, [17:8] left_x, [24:18] glyph_width, [31:25] top_trim
    output logic [gbbs_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,   // [0] kind
    output logic                              m_tlast
);
    import gbbs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gbbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbbs_datapath #(
        .MAX_CELL_SIZE (MAX_CELL_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixel     (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
module tb_top;
    import gbbs_pkg::*;

    localparam int CELL_MAX    = 64;
    localparam int SETTLE      = 24;
    localparam int SCAN_TARGET = 400;
    localparam int RUN_LIMIT   = 600000;

    localparam int LX_LO = INDEX_W;
    localparam int GW_LO = LX_LO + LEFT_X_W;
    localparam int TR_LO = GW_LO + GWIDTH_W;

    typedef struct packed {
        logic                kind;
        logic [INDEX_W-1:0]  glyph;
        logic [LEFT_X_W-1:0] left_x;
        logic [GWIDTH_W-1:0] width;
        logic [TRIM_W-1:0]   trim;
        logic                last;
    } glyph_box_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // one line of a 2-wide cell row: left-only, right-only, full, empty and one-bit ink
    logic [PIXEL_W-1:0] opening_line [32] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFEDC_BA98, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'hFFFF_FFFF, 32'hFFFF_FFFE
    };

    logic [PIXEL_W-1:0] pixel_backlog [$];
    glyph_box_t         expected_boxes [$];
    int                 planned_pixels = 0;
    int                 taken_pixels   = 0;
    int                 mismatches     = 0;
    int                 cycle_count    = 0;
    int                 gap_mode       = 0;
    bit                 px_taken       = 1'b0;

    // scanner mirror
    logic [CFG_W-1:0]   cell_w_reg = 7'd8;
    logic [CFG_W-1:0]   cell_h_reg = 7'd8;
    logic [PIXEL_W-1:0] bg_px      = '0;
    int                 col_pos;
    int                 row_pos;
    int                 top_min;
    bit                 inked  [GRID_CELLS];
    int                 ink_lo [GRID_CELLS];
    int                 ink_hi [GRID_CELLS];

    glyph_cell_bounding_box_scanner_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int cell_span(input int v);
        if (v == 0) return 1;
        if (v > CELL_MAX) return CELL_MAX;
        return v;
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic clear_records();
        int c;
        for (c = 0; c < GRID_CELLS; c++) begin
            inked[c]  = 1'b0;
            ink_lo[c] = 0;
            ink_hi[c] = 0;
        end
    endtask

    task automatic restart_scan();
        col_pos = 0;
        row_pos = 0;
        clear_records();
        top_min = cell_span(cell_h_reg);
    endtask

    task automatic predict_boxes(input logic [PIXEL_W-1:0] px);
        int         cw, ch, cidx, xin, yin, crow, c;
        bit         line_end, frame_end;
        glyph_box_t box;
        cw        = cell_span(cell_w_reg);
        ch        = cell_span(cell_h_reg);
        cidx      = (col_pos / cw) % GRID_CELLS;
        xin       = col_pos % cw;
        yin       = row_pos % ch;
        crow      = (row_pos / ch) % GRID_CELLS;
        line_end  = (col_pos + 1 >= GRID_CELLS * cw);
        frame_end = line_end && (row_pos + 1 >= GRID_CELLS * ch);

        // first pixel of a frame sets the background and is never ink
        if (col_pos == 0 && row_pos == 0) begin
            bg_px   = px;
            top_min = ch;
        end else if (px != bg_px) begin
            if (!inked[cidx]) begin
                inked[cidx]  = 1'b1;
                ink_lo[cidx] = xin;
                ink_hi[cidx] = xin;
            end else begin
                if (xin < ink_lo[cidx]) ink_lo[cidx] = xin;
                if (xin > ink_hi[cidx]) ink_hi[cidx] = xin;
            end
            if (yin < top_min) top_min = yin;
        end

        if (line_end && yin + 1 >= ch) begin
            for (c = 0; c < GRID_CELLS; c++) begin
                box        = '0;
                box.kind   = KIND_GLYPH;
                box.glyph  = INDEX_W'(crow * GRID_CELLS + c);
                box.left_x = LEFT_X_W'(c * cw + (inked[c] ? ink_lo[c] : 0));
                box.width  = GWIDTH_W'(inked[c] ? ink_hi[c] - ink_lo[c] + 1 : cw);
                box.last   = (c == GRID_CELLS - 1) && !frame_end;
                expected_boxes.push_back(box);
            end
            clear_records();
            if (frame_end) begin
                box      = '0;
                box.kind = KIND_TRIM;
                box.trim = TRIM_W'(top_min);
                box.last = 1'b1;
                expected_boxes.push_back(box);
            end
        end

        if (line_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_cell_size(input logic idx, input int val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        if (idx == CFG_CELL_WIDTH) begin
            cell_w_reg = CFG_W'(val);
        end else begin
            cell_h_reg = CFG_W'(val);
        end
        restart_scan();
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // wait until every pixel is taken and every box has come, then let the burst settle
    task automatic drain_results();
        while (pixel_backlog.size() != 0 || s_tvalid || expected_boxes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic play_phase(input int w_raw, input int h_raw, input int npix,
                              input bit pause_halfway);
        int                 ew, eh, col, row, band_top, dens, i;
        logic [PIXEL_W-1:0] bg, px;
        write_cell_size(CFG_CELL_WIDTH, w_raw);
        write_cell_size(CFG_CELL_HEIGHT, h_raw);
        ew  = cell_span(w_raw);
        eh  = cell_span(h_raw);
        col = 0;
        row = 0;
        band_top = 0;
        dens = 0;
        bg = '0;
        for (i = 0; i < npix; i++) begin
            if (col == 0 && row == 0) begin
                case ($urandom_range(3))
                    0:       bg = '0;
                    1:       bg = '1;
                    default: bg = $urandom;
                endcase
                // a band starting at eh leaves the frame without ink
                band_top = $urandom_range(eh);
                dens     = ($urandom_range(3) == 0) ? 2 : $urandom_range(5, 60);
                px       = bg;
            end else if (row % eh >= band_top && coin(dens)) begin
                px = $urandom_range(1) ? PIXEL_W'($urandom)
                                       : bg ^ (32'h1 << $urandom_range(31));
            end else begin
                px = bg;
            end
            if (pause_halfway && i == npix / 2) drain_results();
            pixel_backlog.push_back(px);
            planned_pixels++;
            col++;
            if (col == GRID_CELLS * ew) begin
                col = 0;
                row++;
                if (row == GRID_CELLS * eh) row = 0;
            end
        end
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_boxes(s_tdata);
            px_taken = 1'b1;
            taken_pixels++;
            gap_mode = taken_pixels * 3 / SCAN_TARGET;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || px_taken)) begin
            px_taken = 1'b0;
            if (pixel_backlog.size() != 0 &&
                !coin(gap_mode == 0 ? 8 : (gap_mode == 1 ? 69 : 0))) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_backlog.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !coin(gap_mode == 0 ? 69 : (gap_mode == 1 ? 8 : 0));
    end

    always @(posedge aclk) begin : result_check
        glyph_box_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_boxes.size() == 0) begin
                $display("%0t: expected no transaction, actual tuser %0h tdata %h tlast %0b",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_boxes.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("glyph_index", want.glyph, m_tdata[LX_LO-1:0]);
                check_field("left_x", want.left_x, m_tdata[GW_LO-1:LX_LO]);
                check_field("glyph_width", want.width, m_tdata[TR_LO-1:GW_LO]);
                check_field("top_trim", want.trim, m_tdata[TR_LO+TRIM_W-1:TR_LO]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : stimulus
        int k, wv, hv, ew, eh, npix, i;
        restart_scan();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        write_cell_size(CFG_CELL_WIDTH, 2);
        write_cell_size(CFG_CELL_HEIGHT, 1);
        for (i = 0; i < 32; i++) pixel_backlog.push_back(opening_line[i]);
        drain_results();

        for (k = 0; planned_pixels < SCAN_TARGET; k++) begin
            case (k)
                0: play_phase(0, 0, 256, 1'b1);     // zero sizes, whole frame, hold off halfway
                1: play_phase(127, 127, 40, 1'b0);  // oversize cells, cut off mid-line
                default: begin
                    wv   = $urandom_range(3);
                    hv   = $urandom_range(3);
                    ew   = cell_span(wv);
                    eh   = cell_span(hv);
                    npix = GRID_CELLS * ew * eh;
                    // cut some phases off mid-line
                    if ($urandom_range(3) == 0)
                        npix += $urandom_range(1, GRID_CELLS * ew - 1);
                    play_phase(wv, hv, npix, 1'b0);
                end
            endcase
        end

        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
